@@ rtl/core/glyph_bold_blend_blit_assert.svh @@
// Assertion helpers for the glyph blit block. Both sample on clk and are
// disabled while rst_n is low.
`ifndef GLYPH_BOLD_BLEND_BLIT_ASSERT_SVH
`define GLYPH_BOLD_BLEND_BLIT_ASSERT_SVH

// Same-cycle implication.
`define GBB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GBB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gbb_pkg.sv @@
`default_nettype none

package gbb_pkg;

    // Window entries the 3-bit bold setting can ever reach.
    localparam int WIN_MAX      = 7;
    localparam int DEF_MAX_BOLD = 7;
    localparam logic [8:0] MAX_WIDTH = 9'd256;

    // Register indexes (byte address / 4).
    localparam logic [2:0] REG_BG_COLOUR   = 3'd0;
    localparam logic [2:0] REG_FG_COLOUR   = 3'd1;
    localparam logic [2:0] REG_BOLD_EXTRA  = 3'd2;
    localparam logic [2:0] REG_MONO_MODE   = 3'd3;
    localparam logic [2:0] REG_ROTATE      = 3'd4;
    localparam logic [2:0] REG_GLYPH_WIDTH = 3'd5;

    typedef logic [7:0] gbb_byte_t;

    // Effective configuration, already clamped.
    typedef struct packed {
        logic [23:0] bg;
        logic [23:0] fg;
        logic [2:0]  dx;
        logic        mono;
        logic        rot;
        logic [8:0]  w;
    } gbb_cfg_t;

    // One accepted sample with the row context it needs.
    typedef struct packed {
        gbb_byte_t [WIN_MAX-1:0] win;
        gbb_byte_t               cov;
        logic [8:0]              col;
        logic [7:0]              row;
        logic                    last;
    } gbb_job_t;

    // One output pixel before blending.
    typedef struct packed {
        gbb_byte_t  alpha;
        logic [8:0] x;
        logic [8:0] y;
        logic       done;
    } gbb_pix_t;

    typedef struct packed {
        logic       mid_job;
        logic [2:0] k;
    } gbb_emit_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/gbb_if.sv @@
`default_nettype none

interface gbb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] coverage;
    logic       first_of_glyph;

    modport source (output valid, output coverage, output first_of_glyph, input ready);
    modport sink   (input valid, input coverage, input first_of_glyph, output ready);
endinterface

interface gbb_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_colour;
    logic [8:0]  out_x;
    logic [8:0]  out_y;
    logic        row_done;

    modport source (output valid, output pixel_colour, output out_x, output out_y,
                    output row_done, input ready);
    modport sink   (input valid, input pixel_colour, input out_x, input out_y,
                    input row_done, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gbb_front.sv @@
`default_nettype none

module gbb_front #(
    parameter int MAX_BOLD = gbb_pkg::DEF_MAX_BOLD
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gbb_pkg::gbb_cfg_t cfg,
    gbb_in_if.sink                 in_ch,
    output logic                   job_valid,
    output gbb_pkg::gbb_job_t      job,
    input  wire logic              job_take
);

    localparam int WIN_D = (MAX_BOLD < 1) ? 1 :
                           ((MAX_BOLD > gbb_pkg::WIN_MAX) ? gbb_pkg::WIN_MAX : MAX_BOLD);

    gbb_pkg::gbb_byte_t win_reg [WIN_D];
    gbb_pkg::gbb_byte_t win_next [WIN_D];
    logic [8:0]         col_reg, col_next;
    logic [7:0]         row_reg, row_next;
    logic               job_valid_reg;
    gbb_pkg::gbb_job_t  job_reg, job_next;

    logic [8:0]         col_in;
    logic [8:0]         col_c;
    logic [7:0]         row_c;
    logic               last_c;
    gbb_pkg::gbb_byte_t cov_m;
    logic               accept;

    assign in_ch.ready = !job_valid_reg || job_take;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        col_in = in_ch.first_of_glyph ? 9'd0 : col_reg;
        row_c  = in_ch.first_of_glyph ? 8'd0 : row_reg;
        // A width shrunk mid-row pins the column to the last one.
        col_c  = (col_in >= cfg.w) ? (cfg.w - 9'd1) : col_in;
        last_c = (col_c == (cfg.w - 9'd1));
        if (cfg.mono)
            cov_m = (in_ch.coverage != 8'd0) ? 8'hFF : 8'h00;
        else
            cov_m = in_ch.coverage;

        job_next      = '0;
        job_next.cov  = cov_m;
        job_next.col  = col_c;
        job_next.row  = row_c;
        job_next.last = last_c;
        // Drop earlier samples at the start of a row.
        for (int j = 0; j < WIN_D; j++)
        begin
            job_next.win[j] = (col_c == 9'd0) ? 8'd0 : win_reg[j];
        end

        win_next[0] = cov_m;
        for (int j = 1; j < WIN_D; j++)
        begin
            win_next[j] = job_next.win[j-1];
        end

        col_next = last_c ? 9'd0 : (col_c + 9'd1);
        row_next = last_c ? (row_c + 8'd1) : row_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            for (int j = 0; j < WIN_D; j++)
            begin
                win_reg[j] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                job_valid_reg <= 1'b1;
                col_reg       <= col_next;
                row_reg       <= row_next;
                for (int j = 0; j < WIN_D; j++)
                begin
                    win_reg[j] <= win_next[j];
                end
            end
            else if (job_take)
            begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

`default_nettype wire

@@ rtl/core/gbb_emit.sv @@
`default_nettype none

module gbb_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gbb_pkg::gbb_cfg_t cfg,
    input  wire logic              job_valid,
    input  wire gbb_pkg::gbb_job_t job,
    output logic                   job_take,
    output logic                   pix_valid,
    output gbb_pkg::gbb_pix_t      pix,
    input  wire logic              pix_take,
    output gbb_pkg::gbb_emit_stat_t stat
);

    logic [2:0]        k_reg, k_next;
    logic              pix_valid_reg;
    gbb_pkg::gbb_pix_t pix_reg, pix_next;

    logic       fire;
    logic       k_last;
    logic [2:0] limit;
    logic [8:0] x;
    logic [9:0] y_rot;
    gbb_pkg::gbb_byte_t alpha;

    assign fire     = job_valid && (!pix_valid_reg || pix_take);
    assign k_last   = !job.last || (k_reg == cfg.dx);
    assign job_take = fire && k_last;

    always_comb
    begin
        // Pixel k of a job looks back over dx - k earlier samples.
        limit = cfg.dx - k_reg;
        alpha = job.cov;
        for (int j = 0; j < gbb_pkg::WIN_MAX; j++)
        begin
            if ((3'(j) < limit) && (job.win[j] > alpha))
                alpha = job.win[j];
        end

        x     = job.col + {6'd0, k_reg};
        y_rot = {1'b0, cfg.w} + {7'd0, cfg.dx} - 10'd1 - {1'b0, x};

        pix_next.alpha = alpha;
        pix_next.done  = job.last && (k_reg == cfg.dx);
        if (cfg.rot)
        begin
            pix_next.x = {1'b0, job.row};
            pix_next.y = y_rot[8:0];
        end
        else
        begin
            pix_next.x = x;
            pix_next.y = {1'b0, job.row};
        end

        k_next = k_last ? 3'd0 : (k_reg + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                k_reg         <= k_next;
                pix_valid_reg <= 1'b1;
            end
            else if (pix_take)
            begin
                pix_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix_valid    = pix_valid_reg;
    assign pix          = pix_reg;
    assign stat.mid_job = (k_reg != 3'd0);
    assign stat.k       = k_reg;

endmodule

`default_nettype wire

@@ rtl/core/gbb_blend.sv @@
`default_nettype none

module gbb_blend (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gbb_pkg::gbb_cfg_t cfg,
    input  wire logic              pix_valid,
    input  wire gbb_pkg::gbb_pix_t pix,
    output logic                   pix_take,
    gbb_out_if.source              out_ch
);

    // lo + (hi - lo) * w / 255, floor; the divide is exact for 16-bit products.
    function automatic logic [7:0] blend_ch(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] alpha);
        logic [7:0]  base;
        logic [7:0]  diff;
        logic [7:0]  wgt;
        logic [15:0] p;
        logic [16:0] q;
        if (a < b)
        begin
            base = a;
            diff = b - a;
            wgt  = alpha;
        end
        else
        begin
            base = b;
            diff = a - b;
            wgt  = 8'hFF - alpha;
        end
        p = diff * wgt;
        q = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return base + q[15:8];
    endfunction

    logic        out_valid_reg;
    logic [23:0] colour_reg, colour_next;
    logic [8:0]  x_reg;
    logic [8:0]  y_reg;
    logic        done_reg;

    assign pix_take = pix_valid && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            colour_next[8*c +: 8] = blend_ch(cfg.bg[8*c +: 8], cfg.fg[8*c +: 8], pix.alpha);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_take)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            colour_reg <= colour_next;
            x_reg      <= pix.x;
            y_reg      <= pix.y;
            done_reg   <= pix.done;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pixel_colour = colour_reg;
    assign out_ch.out_x        = x_reg;
    assign out_ch.out_y        = y_reg;
    assign out_ch.row_done     = done_reg;

endmodule

`default_nettype wire

@@ rtl/core/glyph_bold_blend_blit.sv @@
// A sample's first pixel goes through the front job register and the emit pixel
// register into the output register. Throughput: one pixel per cycle and one sample
// per cycle while the output is ready, except the last sample of a row, which holds
// the input off while the emit counter walks out the trailing bold pixels.
// Reset (rst_n, async low): registers to defaults, bold window, column and row to 0.
`default_nettype none
`include "glyph_bold_blend_blit_assert.svh"

module glyph_bold_blend_blit #(
    parameter int MAX_BOLD = gbb_pkg::DEF_MAX_BOLD
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    gbb_in_if.sink           in_ch,
    gbb_out_if.source        out_ch
);

    localparam logic [3:0] BOLD_LIM = 4'(MAX_BOLD);

    // Configuration registers, as written.
    logic [23:0] bg_colour_reg;
    logic [23:0] fg_colour_reg;
    logic [2:0]  bold_extra_reg;
    logic        mono_mode_reg;
    logic        rotate_reg;
    logic [8:0]  glyph_width_reg;

    logic [2:0]  reg_idx;
    logic        wr_en;
    gbb_pkg::gbb_cfg_t cfg;

    // Stage hand-offs.
    logic                    job_valid;
    gbb_pkg::gbb_job_t       job;
    logic                    job_take;
    logic                    pix_valid;
    gbb_pkg::gbb_pix_t       pix;
    logic                    pix_take;
    gbb_pkg::gbb_emit_stat_t emit_stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register write: any word on the access phase lands at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_colour_reg   <= 24'h000000;
            fg_colour_reg   <= 24'hFFFFFF;
            bold_extra_reg  <= 3'd0;
            mono_mode_reg   <= 1'b0;
            rotate_reg      <= 1'b0;
            glyph_width_reg <= 9'd1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                gbb_pkg::REG_BG_COLOUR:   bg_colour_reg   <= pwdata[23:0];
                gbb_pkg::REG_FG_COLOUR:   fg_colour_reg   <= pwdata[23:0];
                gbb_pkg::REG_BOLD_EXTRA:  bold_extra_reg  <= pwdata[2:0];
                gbb_pkg::REG_MONO_MODE:   mono_mode_reg   <= pwdata[0];
                gbb_pkg::REG_ROTATE:      rotate_reg      <= pwdata[0];
                gbb_pkg::REG_GLYPH_WIDTH: glyph_width_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            gbb_pkg::REG_BG_COLOUR:   prdata = {8'd0, bg_colour_reg};
            gbb_pkg::REG_FG_COLOUR:   prdata = {8'd0, fg_colour_reg};
            gbb_pkg::REG_BOLD_EXTRA:  prdata = {29'd0, bold_extra_reg};
            gbb_pkg::REG_MONO_MODE:   prdata = {31'd0, mono_mode_reg};
            gbb_pkg::REG_ROTATE:      prdata = {31'd0, rotate_reg};
            gbb_pkg::REG_GLYPH_WIDTH: prdata = {23'd0, glyph_width_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Clamp once here: a zero width acts as one, oversized width and bold saturate.
    always_comb
    begin
        cfg.bg   = bg_colour_reg;
        cfg.fg   = fg_colour_reg;
        cfg.mono = mono_mode_reg;
        cfg.rot  = rotate_reg;
        cfg.dx   = ({1'b0, bold_extra_reg} > BOLD_LIM) ? BOLD_LIM[2:0] : bold_extra_reg;
        if (glyph_width_reg == 9'd0)
            cfg.w = 9'd1;
        else if (glyph_width_reg > gbb_pkg::MAX_WIDTH)
            cfg.w = gbb_pkg::MAX_WIDTH;
        else
            cfg.w = glyph_width_reg;
    end

    // Front: track column, row and the bold window; hold one sample word.
    gbb_front #(
        .MAX_BOLD (MAX_BOLD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_ch     (in_ch),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    // Emit: one pixel per cycle unless stalled; 1 + clamped bold_extra at a row end.
    gbb_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .pix_valid (pix_valid),
        .pix       (pix),
        .pix_take  (pix_take),
        .stat      (emit_stat)
    );

    // Blend: per-channel mix into the output register.
    gbb_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix       (pix),
        .pix_take  (pix_take),
        .out_ch    (out_ch)
    );

    // The emit counter only runs while a row-end sample is held.
    `GBB_ASSERT_IMP(a_mid_job_held, emit_stat.mid_job, job_valid, "emit counter without sample")
    // The counter never passes the bold setting.
    `GBB_ASSERT_IMP(a_k_bound, 1'b1, emit_stat.k <= cfg.dx, "emit counter beyond bold_extra")
    // An accepted word is always held in the front stage next cycle.
    `GBB_ASSERT_NXT(a_accept_held, in_ch.valid && in_ch.ready, job_valid, "accepted sample lost")

endmodule

`default_nettype wire

@@ bench/glyph_bold_blend_blit_tb.sv @@
`timescale 1ns / 100ps

module glyph_bold_blend_blit_tb;

    localparam int        CYCLE_LIMIT = 400000;
    localparam logic [7:0] FULL_COVER = 8'hFF;

    // One output pixel as it leaves the block.
    typedef struct packed {
        logic [23:0] colour;
        logic [8:0]  x;
        logic [8:0]  y;
        logic        done;
    } pixel_word_t;

    // Shadow of the blit: holds its own copy of the registers, the bold window
    // and the column/row position, and queues the pixels each sample must produce.
    class glyph_pixel_model;
        logic [23:0]        bg;
        logic [23:0]        fg;
        logic [2:0]         dx;
        logic               mono;
        logic               rot;
        logic [8:0]         width;
        gbb_pkg::gbb_byte_t win [gbb_pkg::WIN_MAX];
        logic [8:0]         col;
        logic [7:0]         row;
        pixel_word_t        pending_pixels [$];
        int                 mismatches;

        function new();
            bg         = 24'h000000;
            fg         = 24'hFFFFFF;
            dx         = 3'd0;
            mono       = 1'b0;
            rot        = 1'b0;
            width      = 9'd1;
            col        = '0;
            row        = '0;
            mismatches = 0;
            foreach (win[i]) win[i] = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                gbb_pkg::REG_BG_COLOUR:   bg    = data[23:0];
                gbb_pkg::REG_FG_COLOUR:   fg    = data[23:0];
                gbb_pkg::REG_BOLD_EXTRA:  dx    = data[2:0];
                gbb_pkg::REG_MONO_MODE:   mono  = data[0];
                gbb_pkg::REG_ROTATE:      rot   = data[0];
                gbb_pkg::REG_GLYPH_WIDTH: width = data[8:0];
                default: ;
            endcase
        endfunction

        // Mix bg toward fg channel by channel, rounding down.
        function logic [23:0] blend(logic [7:0] alpha);
            logic [23:0] res;
            int unsigned lo;
            int unsigned hi;
            int unsigned d;
            if (alpha == 8'd0)
                return bg;
            if (alpha == FULL_COVER)
                return fg;
            res = '0;
            for (int ch = 0; ch < 3; ch++)
            begin
                lo = bg[ch*8 +: 8];
                hi = fg[ch*8 +: 8];
                if (lo == hi)
                    d = lo;
                else if (lo < hi)
                    d = lo + (hi - lo) * alpha / 255;
                else
                    d = hi + (lo - hi) * (255 - alpha) / 255;
                res[ch*8 +: 8] = d[7:0];
            end
            return res;
        endfunction

        function void push_pixel(logic [7:0] alpha, int unsigned x, int unsigned w,
                                 int unsigned d, logic done);
            pixel_word_t p;
            int unsigned ox;
            int unsigned oy;
            if (rot)
            begin
                ox = row;
                oy = w + d - 1 - x;
            end
            else
            begin
                ox = x;
                oy = row;
            end
            p.colour = blend(alpha);
            p.x      = ox[8:0];
            p.y      = oy[8:0];
            p.done   = done;
            pending_pixels.push_back(p);
        endfunction

        function void take_sample(logic [7:0] cov, logic first);
            int unsigned w;
            int unsigned d;
            int unsigned c;
            logic [7:0]  v;
            logic [7:0]  a;
            w = width;
            if (w == 0)
                w = 1;
            if (w > gbb_pkg::MAX_WIDTH)
                w = gbb_pkg::MAX_WIDTH;
            d = dx;
            if (first)
            begin
                col = '0;
                row = '0;
            end
            // A column past a shrunk width counts as the last column.
            if (col >= w)
                col = 9'(w - 1);
            c = col;
            if (c == 0)
                foreach (win[i]) win[i] = '0;
            v = cov;
            if (mono && v != 0)
                v = FULL_COVER;

            a = v;
            for (int j = 0; j < d; j++)
                if (win[j] > a)
                    a = win[j];

            if (c + 1 < w)
                push_pixel(a, c, w, d, 1'b0);
            else
            begin
                push_pixel(a, c, w, d, d == 0);
                // Trailing bold pixels: the window shrinks by one each step.
                for (int k = 0; k < d; k++)
                begin
                    a = v;
                    for (int j = 0; j + 1 + k < d; j++)
                        if (win[j] > a)
                            a = win[j];
                    push_pixel(a, w + k, w, d, k + 1 == d);
                end
            end

            for (int i = gbb_pkg::WIN_MAX - 1; i > 0; i--)
                win[i] = win[i-1];
            win[0] = v;

            if (c + 1 >= w)
            begin
                col = '0;
                row = row + 8'd1;
            end
            else
                col = 9'(c + 1);
        endfunction

        function void check_pixel(pixel_word_t got);
            pixel_word_t want;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel word: colour %06h x %0d y %0d done %0b",
                             got.colour, got.x, got.y, got.done);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.colour !== want.colour || got.x !== want.x ||
                got.y !== want.y || got.done !== want.done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"pixel mismatch: expected colour %06h x %0d y %0d done %0b,",
                              " got colour %06h x %0d y %0d done %0b"},
                             want.colour, want.x, want.y, want.done,
                             got.colour, got.x, got.y, got.done);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gbb_in_if  in_bus ();
    gbb_out_if out_bus ();

    glyph_bold_blend_blit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_bus),
        .out_ch  (out_bus)
    );

    glyph_pixel_model model;
    bit               idle_on;      // random gaps and stalls allowed
    bit               pressure_go;  // start the long output hold-off
    logic             rx_hold;
    int unsigned      cycle_count = 0;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Bail out if the block wedges.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Output side: check every accepted word, then pick next cycle's ready.
    initial
    begin : pixel_sink
        int          stall_left;
        logic        rdy_next;
        pixel_word_t got;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_bus.valid && out_bus.ready)
            begin
                got.colour = out_bus.pixel_colour;
                got.x      = out_bus.out_x;
                got.y      = out_bus.out_y;
                got.done   = out_bus.row_done;
                model.check_pixel(got);
            end
            if (rx_hold)
                rdy_next = 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy_next = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                // Start a stall burst, this cycle included.
                stall_left = $urandom_range(1, 16) - 1;
                rdy_next   = 1'b0;
            end
            else
                rdy_next = 1'b1;
            out_bus.ready <= rdy_next;
        end
    end

    // Hold the output off for a long stretch so the block backs up into its input.
    initial
    begin : rx_hold_off
        rx_hold = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Write one register: setup phase, then access phase until pready.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        model.write_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write all six registers; fill unused upper bits with junk.
    task automatic write_cfg(input logic [23:0] bg, input logic [23:0] fg,
                             input logic [2:0] dx, input logic mono, input logic rot,
                             input logic [8:0] w);
        apb_write(gbb_pkg::REG_BG_COLOUR,   {8'($urandom()), bg});
        apb_write(gbb_pkg::REG_FG_COLOUR,   {8'($urandom()), fg});
        apb_write(gbb_pkg::REG_BOLD_EXTRA,  {29'($urandom()), dx});
        apb_write(gbb_pkg::REG_MONO_MODE,   {31'($urandom()), mono});
        apb_write(gbb_pkg::REG_ROTATE,      {31'($urandom()), rot});
        apb_write(gbb_pkg::REG_GLYPH_WIDTH, {23'($urandom()), w});
    endtask

    // Offer one sample and hold it until the block takes the word.
    task automatic send_sample(input logic [7:0] cov, input logic first);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_bus.valid          <= 1'b1;
        in_bus.coverage       <= cov;
        in_bus.first_of_glyph <= first;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        model.take_sample(cov, first);
    endtask

    // Drop valid and let every expected pixel come out before touching registers.
    task automatic drain_pixels();
        in_bus.valid <= 1'b0;
        while (model.pending_pixels.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Glyph-shaped stream: first_of_glyph on the first sample of each glyph,
    // glyphs a whole number of rows long; noisy streams flip the flag now and then.
    task automatic stream_glyphs(input int count, input int unsigned row_len,
                                 input bit noisy, input int min_rows, input int max_rows);
        int unsigned pos;
        int unsigned glyph_len;
        logic        first;
        logic [7:0]  cov;
        pos       = 0;
        glyph_len = row_len * $urandom_range(min_rows, max_rows);
        for (int i = 0; i < count; i++)
        begin
            first = (pos == 0);
            if (noisy && $urandom_range(0, 15) == 0)
                first = ~first;
            case ($urandom_range(0, 3))
                0:       cov = 8'd0;
                1:       cov = FULL_COVER;
                default: cov = 8'($urandom());
            endcase
            send_sample(cov, first);
            pos++;
            if (pos >= glyph_len)
            begin
                pos       = 0;
                glyph_len = row_len * $urandom_range(min_rows, max_rows);
            end
        end
    endtask

    function automatic logic [23:0] pick_colour();
        case ($urandom_range(0, 3))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    initial
    begin : stimulus
        logic [23:0] bg;
        logic [23:0] fg;
        logic [2:0]  dx;
        logic [8:0]  w;
        int unsigned rl;

        model       = new();
        idle_on     = 1'b1;
        pressure_go = 1'b0;
        rst_n       = 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        in_bus.valid          <= 1'b0;
        in_bus.coverage       <= '0;
        in_bus.first_of_glyph <= 1'b0;
        out_bus.ready         <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: one-column rows, no bold, black to white.
        send_sample(8'd0, 1'b1);
        send_sample(FULL_COVER, 1'b0);
        send_sample(8'd128, 1'b0);
        send_sample(8'd1, 1'b0);
        drain_pixels();

        // Widest bold on a narrow row, colours inverted.
        write_cfg(24'hFFFFFF, 24'h000000, 3'd7, 1'b0, 1'b0, 9'd3);
        send_sample(FULL_COVER, 1'b1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd77, 1'b0);
        send_sample(8'd0, 1'b0);
        drain_pixels();

        // Zero width acts as one; mono and rotation on, channels blend both ways.
        write_cfg(24'h123456, 24'h80FF00, 3'd2, 1'b1, 1'b1, 9'd0);
        send_sample(8'd0, 1'b1);
        send_sample(8'd1, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd200, 1'b0);
        drain_pixels();

        // Width beyond the limit clamps; equal colours.
        write_cfg(24'h5A5A5A, 24'h5A5A5A, 3'd3, 1'b0, 1'b1, 9'd300);
        send_sample(FULL_COVER, 1'b1);
        send_sample(8'd7, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd254, 1'b0);
        send_sample(8'd9, 1'b0);
        drain_pixels();

        // Shrink the width while the column sits past it.
        write_cfg(24'h0000FF, 24'hFF0000, 3'd1, 1'b0, 1'b0, 9'd2);
        send_sample(8'd100, 1'b0);
        send_sample(8'd50, 1'b0);
        send_sample(8'd0, 1'b0);
        drain_pixels();

        // Random settings, short glyph-shaped streams with some broken flags.
        for (int p = 0; p < 10; p++)
        begin
            bg = pick_colour();
            fg = (p == 3) ? bg : pick_colour();
            dx = (p == 0) ? 3'd0 : (p == 1) ? 3'd7 : 3'($urandom_range(0, 7));
            case (p)
                4:       w = 9'd256;
                5:       w = 9'd511;
                6:       w = 9'd0;
                default: w = 9'($urandom_range(1, 4));
            endcase
            write_cfg(bg, fg, dx, 1'($urandom()), 1'($urandom()), w);
            rl = (w == 0) ? 1 : (w > gbb_pkg::MAX_WIDTH) ? gbb_pkg::MAX_WIDTH : w;
            stream_glyphs(4, rl, 1'b1, 1, 3);
            drain_pixels();
        end

        // One long glyph of single-column rows so the row counter wraps;
        // hold the output off meanwhile so the input backs up.
        write_cfg(pick_colour(), pick_colour(), 3'($urandom_range(0, 7)),
                  1'($urandom()), 1'b1, 9'd1);
        pressure_go = 1'b1;
        stream_glyphs(258, 1, 1'b0, 300, 300);
        drain_pixels();

        // Last stretch runs flat out on both sides.
        idle_on = 1'b0;
        for (int p = 0; p < 2; p++)
        begin
            w = 9'($urandom_range(1, 10));
            write_cfg(pick_colour(), pick_colour(), 3'($urandom_range(0, 7)),
                      1'($urandom()), 1'($urandom()), w);
            stream_glyphs(10, w, 1'b0, 1, 4);
            drain_pixels();
        end

        repeat (20) @(posedge clk);
        if (model.mismatches == 0 && model.pending_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
